// File: design/dpp_pkg.sv
`default_nettype none
package dpp_pkg;

	localparam int COORD_BITS = 12;
	localparam int DEPTH_BITS = 16;
	localparam int MASK_W     = 8;
	localparam int OUT_W      = 24;
	localparam int HALF_W     = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	localparam int UQ_W      = (COORD_BITS + 4 > HALF_W) ? COORD_BITS + 4 : HALF_W;
	localparam int DU_W      = UQ_W + 1;
	localparam int WIN_W     = (DEPTH_BITS > HALF_W) ? DEPTH_BITS : HALF_W;
	localparam int PD_W      = DEPTH_BITS + HALF_W;
	localparam int PX_W      = DU_W + PD_W + 1;
	localparam int CAM_SHIFT = 28;
	localparam int CAM_W     = DU_W + PD_W - CAM_SHIFT + 1;
	localparam int Z_W       = DEPTH_BITS + 1;
	localparam int OP_W      = (CAM_W > Z_W) ? CAM_W : Z_W;
	localparam int PR_W      = OP_W + HALF_W;
	localparam int ROT_SHIFT = 14;
	localparam int ACC_W     = (PR_W + 2 > ROT_SHIFT + OUT_W + 1) ?
		PR_W + 2 : ROT_SHIFT + OUT_W + 1;

	localparam logic [31:0] RST_DEPTH_WINDOW = 32'hA000_0029;
	localparam logic [31:0] RST_PRINCIPAL    = 32'h1443_0DE5;
	localparam logic [31:0] RST_INV_FOCAL    = 32'h7AD6_7AEE;
	localparam logic [63:0] RST_ROW_X        = 64'h4000_0000_0000_0000;
	localparam logic [63:0] RST_ROW_Y        = 64'h0000_4000_0000_0000;
	localparam logic [63:0] RST_ROW_Z        = 64'h0000_0000_4000_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEPTH_WINDOW = 3'd0,
		REG_PRINCIPAL    = 3'd1,
		REG_INV_FOCAL    = 3'd2,
		REG_ROW_X        = 3'd3,
		REG_ROW_Y        = 3'd4,
		REG_ROW_Z        = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [HALF_W-1:0] r0;
		logic [HALF_W-1:0] r1;
		logic [HALF_W-1:0] r2;
		logic [HALF_W-1:0] t;
	} row_t;

	typedef struct packed {
		logic [HALF_W-1:0] dmax;
		logic [HALF_W-1:0] dmin;
		logic [HALF_W-1:0] cx;
		logic [HALF_W-1:0] cy;
		logic [HALF_W-1:0] fx;
		logic [HALF_W-1:0] fy;
		row_t              row_x;
		row_t              row_y;
		row_t              row_z;
	} cfg_t;

	typedef struct packed {
		logic signed [OP_W-1:0] x;
		logic signed [OP_W-1:0] y;
		logic signed [OP_W-1:0] z;
	} cam_t;

endpackage
`default_nettype wire

// File: design/dpp_if.sv
`default_nettype none
interface dpp_pixel_if;
	import dpp_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [DEPTH_BITS-1:0] depth;
	logic [MASK_W-1:0]     mask;
	logic [COORD_BITS-1:0] column;
	logic [COORD_BITS-1:0] row;
	modport source (output valid, depth, mask, column, row, input ready);
	modport sink (input valid, depth, mask, column, row, output ready);
endinterface

interface dpp_point_if;
	import dpp_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] point_x;
	logic signed [OUT_W-1:0] point_y;
	logic signed [OUT_W-1:0] point_z;
	modport source (output valid, point_x, point_y, point_z, input ready);
	modport sink (input valid, point_x, point_y, point_z, output ready);
endinterface

interface dpp_cfg_if;
	import dpp_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: design/dpp_cfg_regs.sv
`default_nettype none
module dpp_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	dpp_cfg_if.sink       cfg,
	output dpp_pkg::cfg_t csr
);
	import dpp_pkg::*;

	logic [31:0] window_q;
	logic [31:0] principal_q;
	logic [31:0] focal_q;
	logic [63:0] row_x_q;
	logic [63:0] row_y_q;
	logic [63:0] row_z_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q    <= RST_DEPTH_WINDOW;
			principal_q <= RST_PRINCIPAL;
			focal_q     <= RST_INV_FOCAL;
			row_x_q     <= RST_ROW_X;
			row_y_q     <= RST_ROW_Y;
			row_z_q     <= RST_ROW_Z;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				REG_DEPTH_WINDOW: window_q    <= cfg.data[31:0];
				REG_PRINCIPAL:    principal_q <= cfg.data[31:0];
				REG_INV_FOCAL:    focal_q     <= cfg.data[31:0];
				REG_ROW_X:        row_x_q     <= cfg.data;
				REG_ROW_Y:        row_y_q     <= cfg.data;
				REG_ROW_Z:        row_z_q     <= cfg.data;
				default: ;
			endcase
		end
	end

	always_comb begin
		csr.dmax  = window_q[31:16];
		csr.dmin  = window_q[15:0];
		csr.cx    = principal_q[31:16];
		csr.cy    = principal_q[15:0];
		csr.fx    = focal_q[31:16];
		csr.fy    = focal_q[15:0];
		csr.row_x = row_t'(row_x_q);
		csr.row_y = row_t'(row_y_q);
		csr.row_z = row_t'(row_z_q);
	end

endmodule
`default_nettype wire

// File: design/dpp_project.sv
`default_nettype none
module dpp_project (
	input  logic          clk,
	input  logic          arst_n,
	dpp_pixel_if.sink     pixel,
	input  dpp_pkg::cfg_t csr,
	output logic          cam_valid,
	input  logic          cam_ready,
	output dpp_pkg::cam_t cam
);
	import dpp_pkg::*;

	localparam logic [PX_W-1:0] CAM_HALF = PX_W'(1) << (CAM_SHIFT - 1);

	logic                  en1, en2, en3, en4;
	logic                  keep;
	logic [WIN_W-1:0]      d_w, dmin_w, dmax_w;
	logic [UQ_W-1:0]       u_q, v_q;
	logic signed [DU_W-1:0] du0, dv0;

	logic                   v_s1, v_s2, v_s3, v_s4;
	logic [DEPTH_BITS-1:0]  d_s1, d_s2, d_s3;
	logic signed [DU_W-1:0] du_s1, dv_s1, du_s2, dv_s2;
	logic [PD_W-1:0]        pdx_s2, pdy_s2;
	logic signed [PX_W-1:0] px_s3, py_s3;
	logic [PX_W-1:0]        rx, ry;
	cam_t                   cam_s4;

	assign en4 = !v_s4 || cam_ready;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign pixel.ready = en1;

	// pixel filter and offset from the optical centre (Q.4 pixels)
	always_comb begin
		d_w    = WIN_W'(pixel.depth);
		dmin_w = WIN_W'(csr.dmin);
		dmax_w = WIN_W'(csr.dmax);
		keep   = (pixel.mask != '0) && (d_w >= dmin_w) && (d_w <= dmax_w);
		u_q    = UQ_W'({pixel.column, 4'b0000});
		v_q    = UQ_W'({pixel.row, 4'b0000});
		du0    = $signed({1'b0, u_q}) - $signed({1'b0, UQ_W'(csr.cx)});
		dv0    = $signed({1'b0, v_q}) - $signed({1'b0, UQ_W'(csr.cy)});
	end

	// round half away from zero
	always_comb begin
		rx = px_s3 + CAM_HALF - {{(PX_W-1){1'b0}}, px_s3[PX_W-1]};
		ry = py_s3 + CAM_HALF - {{(PX_W-1){1'b0}}, py_s3[PX_W-1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= pixel.valid && keep;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			d_s1  <= pixel.depth;
			du_s1 <= du0;
			dv_s1 <= dv0;
		end
		if (en2) begin
			d_s2   <= d_s1;
			du_s2  <= du_s1;
			dv_s2  <= dv_s1;
			pdx_s2 <= d_s1 * csr.fx;
			pdy_s2 <= d_s1 * csr.fy;
		end
		if (en3) begin
			d_s3  <= d_s2;
			px_s3 <= du_s2 * $signed({1'b0, pdx_s2});
			py_s3 <= dv_s2 * $signed({1'b0, pdy_s2});
		end
		if (en4) begin
			cam_s4.x <= OP_W'($signed(rx[CAM_SHIFT +: CAM_W]));
			cam_s4.y <= OP_W'($signed(ry[CAM_SHIFT +: CAM_W]));
			cam_s4.z <= OP_W'($signed({1'b0, d_s3}));
		end
	end

	assign cam_valid = v_s4;
	assign cam       = cam_s4;

endmodule
`default_nettype wire

// File: design/dpp_transform.sv
`default_nettype none
module dpp_transform (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cam_valid,
	output logic          cam_ready,
	input  dpp_pkg::cam_t cam,
	input  dpp_pkg::cfg_t csr,
	dpp_point_if.source   point
);
	import dpp_pkg::*;

	localparam logic [ACC_W-1:0] ROT_HALF = ACC_W'(1) << (ROT_SHIFT - 1);
	localparam int               HI_LSB   = ROT_SHIFT + OUT_W - 1;

	logic en5, en6, en7;
	logic v_s5, v_s6, v_s7;

	row_t rows [3];

	logic signed [PR_W-1:0]   prod_s5 [3][3];
	logic signed [HALF_W-1:0] t_s5    [3];
	logic signed [ACC_W-1:0]  acc     [3];
	logic signed [ACC_W-1:0]  acc_s6  [3];
	logic [ACC_W-1:0]         rnd     [3];
	logic [OUT_W-1:0]         sat     [3];
	logic [OUT_W-1:0]         pt_s7   [3];

	assign en7 = !v_s7 || point.ready;
	assign en6 = !v_s6 || en7;
	assign en5 = !v_s5 || en6;
	assign cam_ready = en5;

	always_comb begin
		rows[0] = csr.row_x;
		rows[1] = csr.row_y;
		rows[2] = csr.row_z;
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			acc[i] = ACC_W'(prod_s5[i][0]) + ACC_W'(prod_s5[i][1]) + ACC_W'(prod_s5[i][2])
				+ (ACC_W'(t_s5[i]) <<< ROT_SHIFT);
		end
	end

	// round half away from zero, then clamp to signed Q24.0
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rnd[i] = acc_s6[i] + ROT_HALF - {{(ACC_W-1){1'b0}}, acc_s6[i][ACC_W-1]};
			if ((rnd[i][ACC_W-1:HI_LSB] == '0) || (rnd[i][ACC_W-1:HI_LSB] == '1)) begin
				sat[i] = rnd[i][ROT_SHIFT +: OUT_W];
			end else if (rnd[i][ACC_W-1]) begin
				sat[i] = {1'b1, {(OUT_W-1){1'b0}}};
			end else begin
				sat[i] = {1'b0, {(OUT_W-1){1'b1}}};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en5) v_s5 <= cam_valid;
			if (en6) v_s6 <= v_s5;
			if (en7) v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (en5) begin
				prod_s5[i][0] <= $signed(rows[i].r0) * cam.x;
				prod_s5[i][1] <= $signed(rows[i].r1) * cam.y;
				prod_s5[i][2] <= $signed(rows[i].r2) * cam.z;
				t_s5[i]       <= $signed(rows[i].t);
			end
			if (en6) acc_s6[i] <= acc[i];
			if (en7) pt_s7[i]  <= sat[i];
		end
	end

	assign point.valid   = v_s7;
	assign point.point_x = $signed(pt_s7[0]);
	assign point.point_y = $signed(pt_s7[1]);
	assign point.point_z = $signed(pt_s7[2]);

endmodule
`default_nettype wire

// File: design/depth_pixel_to_point.sv
`default_nettype none
// Channel  Role    Payload                           Handshake
// pixel    sink    depth, mask, column, row          valid/ready
// point    source  point_x, point_y, point_z         valid/ready
// cfg      sink    index, data                       valid/ready (always ready)
//
// Seven register stages: filter, depth x 1/f, offset x product, round,
// nine row products, row sums, round and clamp into the output register.
// One item per cycle unless point.ready stalls; the last stage drives point.valid.
// Each stage advances when its successor is empty or moving, so bubbles close up.
// Masked or out-of-window pixels are taken and leave no item.
// Reset clears valid bits and loads the default camera and transform.
module depth_pixel_to_point (
	input  logic        clk,
	input  logic        arst_n,
	dpp_pixel_if.sink   pixel,
	dpp_point_if.source point,
	dpp_cfg_if.sink     cfg
);
	import dpp_pkg::*;

	cfg_t csr;
	cam_t cam;
	logic cam_valid;
	logic cam_ready;

	dpp_cfg_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.csr    (csr)
	);

	dpp_project u_project (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixel     (pixel),
		.csr       (csr),
		.cam_valid (cam_valid),
		.cam_ready (cam_ready),
		.cam       (cam)
	);

	dpp_transform u_transform (
		.clk       (clk),
		.arst_n    (arst_n),
		.cam_valid (cam_valid),
		.cam_ready (cam_ready),
		.cam       (cam),
		.csr       (csr),
		.point     (point)
	);

	// backpressure at the input only when every stage is full
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!pixel.ready |-> (point.valid && !point.ready))
		else $error("input stalled without output backpressure");

	a_mid_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!cam_ready |-> (point.valid && !point.ready))
		else $error("transform stalled without output backpressure");

	a_cam_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cam_valid && !cam_ready) |=> cam_valid)
		else $error("camera point lost while stalled");

endmodule
`default_nettype wire
